// ----- rtl/core/etsm_pkg.sv -----
// Shared types and constants for the event track summary and signature map block.
// No dependencies; every other file in rtl/core refers to it by scoped names.
package etsm_pkg;

    localparam logic [14:0] TPQ_RESET     = 15'd480;
    localparam logic        REBUILD_RESET = 1'b1;

    // Event kinds
    localparam logic [1:0] KIND_END = 2'd1;
    localparam logic [1:0] KIND_SIG = 2'd2;

    // Configuration register indexes
    localparam logic CFG_TPQ     = 1'b0;
    localparam logic CFG_REBUILD = 1'b1;

    localparam logic [23:0] SEL_COUNT_MAX = 24'hFFFFFF;

    // Remainder unit: 31-bit distance by 25-bit bar length
    localparam int DIV_BITS  = 31;
    localparam int DIVISOR_W = 25;

    typedef struct packed {
        logic signed [31:0] start_time;
        logic signed [31:0] stop_time;
        logic               has_duration;
        logic               has_channel;
        logic [5:0]         channel_num;
        logic [1:0]         event_kind;
        logic               is_selected;
        logic [7:0]         sig_numerator;
        logic [3:0]         sig_denominator_log;
        logic               last_in_track;
    } t_in;

    typedef struct packed {
        logic               sig_write;
        logic [7:0]         sig_entry_index;
        logic [30:0]        sig_entry_time;
        logic [16:0]        sig_beat_len;
        logic [24:0]        sig_bar_len;
        logic [23:0]        sel_count;
        logic signed [31:0] min_sel_time;
        logic signed [31:0] max_sel_time;
        logic signed [31:0] latest_stop;
        logic signed [31:0] logical_len;
        logic [63:0]        used_mask;
        logic [63:0]        selected_mask;
    } t_out;

    typedef struct packed {
        logic [23:0]        sel_count;
        logic signed [31:0] min_sel;
        logic signed [31:0] max_sel;
        logic signed [31:0] stop_max;
        logic signed [31:0] length;
        logic [63:0]        used;
        logic [63:0]        selected;
    } t_sum;

    localparam t_sum SUM_CLEAR = '{
        sel_count: 24'd0,
        min_sel:   32'sh7FFFFFFF,
        max_sel:   32'sh80000000,
        stop_max:  32'sd0,
        length:    32'sd0,
        used:      64'd0,
        selected:  64'd0
    };

    typedef struct packed {
        logic        write;
        logic [7:0]  index;
        logic [30:0] time_tick;
        logic [16:0] beat;
        logic [24:0] bar;
    } t_sig_res;

    typedef struct packed {
        logic        en;
        logic [14:0] tpq;
    } t_reload;

endpackage

// ----- rtl/core/etsm_div.sv -----
// Radix-2 restoring remainder unit, one quotient bit per cycle.
// Depends on etsm_pkg for operand widths.
module etsm_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [etsm_pkg::DIV_BITS-1:0]  i_dividend,
    input  logic [etsm_pkg::DIVISOR_W-1:0] i_divisor,
    output logic                           o_done,
    output logic [etsm_pkg::DIVISOR_W-1:0] o_rem
);
    localparam int DvdW = etsm_pkg::DIV_BITS;
    localparam int DvsW = etsm_pkg::DIVISOR_W;
    localparam int CntW = $clog2(DvdW);

    logic            r_run;
    logic            r_done;
    logic [CntW-1:0] r_cnt;
    logic [DvsW-1:0] r_rem;
    logic [DvdW-1:0] r_dvd;
    logic [DvsW:0]   w_part;
    logic [DvsW+1:0] w_diff;

    assign w_part = {r_rem, r_dvd[DvdW-1]};
    assign w_diff = {1'b0, w_part} - {2'b00, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CntW'(DvdW - 1);
                r_rem <= '0;
                r_dvd <= i_dividend;
            end else if (r_run) begin
                // restore when the trial subtract goes negative
                r_rem <= w_diff[DvsW+1] ? w_part[DvsW-1:0] : w_diff[DvsW-1:0];
                r_dvd <= r_dvd << 1;
                if (r_cnt == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ----- rtl/core/etsm_stats.sv -----
// Running summaries of the pass: selected count and span, stop max, length, channel masks.
// Depends on etsm_pkg for the item and summary types.
module etsm_stats #(
    parameter int NUM_CHANNELS = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  etsm_pkg::t_in  i_item,
    input  logic           i_commit,
    output etsm_pkg::t_sum o_next
);
    etsm_pkg::t_sum     r_sum;
    etsm_pkg::t_sum     n_sum;
    logic signed [31:0] w_last;
    logic [63:0]        w_ch_bit;

    assign w_last = i_item.has_duration ? i_item.stop_time : i_item.start_time;
    assign w_ch_bit = (i_item.has_channel &&
                       ({1'b0, i_item.channel_num} < 7'(NUM_CHANNELS)))
                      ? (64'd1 << i_item.channel_num) : 64'd0;

    always_comb begin
        n_sum      = r_sum;
        n_sum.used = r_sum.used | w_ch_bit;
        if (i_item.event_kind == etsm_pkg::KIND_END && r_sum.length <= 32'sd0) begin
            n_sum.length = w_last;
        end
        if (i_item.is_selected) begin
            n_sum.selected = r_sum.selected | w_ch_bit;
            if (i_item.start_time < r_sum.min_sel) begin
                n_sum.min_sel = i_item.start_time;
            end
            if (w_last > r_sum.max_sel) begin
                n_sum.max_sel = w_last;
            end
            if (r_sum.sel_count != etsm_pkg::SEL_COUNT_MAX) begin
                n_sum.sel_count = r_sum.sel_count + 24'd1;
            end
        end
        if (w_last > r_sum.stop_max) begin
            n_sum.stop_max = w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= etsm_pkg::SUM_CLEAR;
        end else if (i_commit) begin
            r_sum <= i_item.last_in_track ? etsm_pkg::SUM_CLEAR : n_sum;
        end
    end

    assign o_next = n_sum;

endmodule

// ----- rtl/core/etsm_sig.sv -----
// Time-signature sequencer: beat/bar lengths, change detect, bar alignment via etsm_div.
// Depends on etsm_pkg and etsm_div.
module etsm_sig #(
    parameter int MAX_SIG_ENTRIES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  etsm_pkg::t_in      i_item,
    input  logic [14:0]        i_tpq,
    input  logic               i_rebuild,
    input  etsm_pkg::t_reload  i_reload,
    input  logic               i_commit,
    output logic               o_done,
    output etsm_pkg::t_sig_res o_res
);
    localparam int              IdxW   = $clog2(MAX_SIG_ENTRIES);
    localparam logic [IdxW-1:0] IdxMax = IdxW'(MAX_SIG_ENTRIES - 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_BEAT = 6'b000010,
        S_BAR  = 6'b000100,
        S_CHK  = 6'b001000,
        S_DIV  = 6'b010000,
        S_DONE = 6'b100000
    } t_sig_state;

    t_sig_state      r_state;
    t_sig_state      n_state;
    logic [16:0]     r_beat;
    logic [24:0]     r_bar;
    logic [30:0]     r_t;
    logic [30:0]     r_cur_time;
    logic [16:0]     r_cur_beat;
    logic [24:0]     r_cur_bar;
    logic [IdxW-1:0] r_cur_idx;
    logic            r_w;
    logic [IdxW-1:0] r_w_idx;
    logic [30:0]     r_w_time;

    logic [16:0]     w_tpq4;
    logic [16:0]     w_tpq3;
    logic [16:0]     w_beat_raw;
    logic [24:0]     w_prod;
    logic [31:0]     w_dist;
    logic            w_pos;
    logic            w_ge;
    logic            w_write;
    logic            w_bar_zero;
    logic [IdxW-1:0] w_idx_inc;
    logic            w_div_start;
    logic            w_div_done;
    logic [24:0]     w_rem;
    logic [IdxW+7:0] w_idx_ext;

    assign w_tpq4     = {i_tpq, 2'b00};
    assign w_tpq3     = {2'b00, i_tpq} + {1'b0, i_tpq, 1'b0};
    assign w_beat_raw = w_tpq4 >> i_item.sig_denominator_log;
    assign w_prod     = {8'd0, r_beat} * {17'd0, i_item.sig_numerator};

    // Distance from the current entry; only a positive one of at least a bar opens an entry
    assign w_dist     = {1'b0, r_t} - {1'b0, r_cur_time};
    assign w_pos      = !w_dist[31] && (w_dist != 32'd0);
    assign w_ge       = w_dist[30:0] >= {6'd0, r_cur_bar};
    assign w_bar_zero = (r_cur_bar == 25'd0);
    assign w_write    = (i_item.event_kind == etsm_pkg::KIND_SIG) && i_rebuild &&
                        ((r_beat != r_cur_beat) || (r_bar != r_cur_bar));
    assign w_idx_inc  = (r_cur_idx == IdxMax) ? r_cur_idx : r_cur_idx + 1'b1;

    assign w_div_start = (r_state == S_CHK) && w_write && w_pos && w_ge && !w_bar_zero;

    etsm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dist[30:0]),
        .i_divisor  (r_cur_bar),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_start) n_state = S_BEAT;
            S_BEAT: n_state = S_BAR;
            S_BAR:  n_state = S_CHK;
            S_CHK:  n_state = w_div_start ? S_DIV : S_DONE;
            S_DIV:  if (w_div_done) n_state = S_DONE;
            S_DONE: if (i_commit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cur_time <= '0;
            r_cur_idx  <= '0;
            r_cur_beat <= {2'b00, etsm_pkg::TPQ_RESET};
            r_cur_bar  <= {8'd0, etsm_pkg::TPQ_RESET, 2'b00};
        end else begin
            r_state <= n_state;
            case (r_state)
                S_BEAT: begin
                    r_beat <= w_beat_raw;
                    r_t    <= i_item.start_time[31] ? 31'd0 : i_item.start_time[30:0];
                end
                S_BAR: begin
                    // fall back to defaults for a zero-length bar or beat
                    r_bar  <= (w_prod == 25'd0) ? {8'd0, w_tpq3} : w_prod;
                    r_beat <= (r_beat == 17'd0) ? {2'b00, i_tpq} : r_beat;
                end
                S_CHK: begin
                    r_w      <= w_write;
                    r_w_idx  <= r_cur_idx;
                    r_w_time <= r_cur_time;
                    if (w_pos && w_ge && w_bar_zero) begin
                        r_w_idx  <= w_idx_inc;
                        r_w_time <= r_t;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_w_idx  <= w_idx_inc;
                        r_w_time <= r_t - {6'd0, w_rem};
                    end
                end
                S_DONE: begin
                    if (i_commit) begin
                        if (i_item.last_in_track) begin
                            r_cur_time <= '0;
                            r_cur_idx  <= '0;
                            r_cur_beat <= {2'b00, i_tpq};
                            r_cur_bar  <= {8'd0, i_tpq, 2'b00};
                        end else if (r_w) begin
                            r_cur_time <= r_w_time;
                            r_cur_idx  <= r_w_idx;
                            r_cur_beat <= r_beat;
                            r_cur_bar  <= r_bar;
                        end
                    end
                end
                default: ;
            endcase
            if (i_reload.en) begin
                r_cur_beat <= {2'b00, i_reload.tpq};
                r_cur_bar  <= {8'd0, i_reload.tpq, 2'b00};
            end
        end
    end

    assign w_idx_ext = {8'd0, r_w_idx};
    assign o_done    = (r_state == S_DONE);

    always_comb begin
        o_res       = '0;
        o_res.write = r_w;
        if (r_w) begin
            o_res.index     = w_idx_ext[7:0];
            o_res.time_tick = r_w_time;
            o_res.beat      = r_beat;
            o_res.bar       = r_bar;
        end
    end

endmodule

// ----- rtl/core/event_track_summary_and_sig_map.sv -----
// Event track summary and signature map: top level with handshakes, config and result register.
// Each item steps through the signature states beat, bar and check, and a divide state when a
// signature change crosses a bar boundary, running the 31-step radix-2 remainder loop in etsm_div.
// Items are taken one at a time, and the next item is taken while a result waits in the
// output register. Reset (synchronous, active low) restores the register defaults and clears
// all summaries and the current map entry.
module event_track_summary_and_sig_map #(
    parameter int NUM_CHANNELS    = 64,
    parameter int MAX_SIG_ENTRIES = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  etsm_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output etsm_pkg::t_out o_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic           i_cfg_index,
    input  logic [14:0]    i_cfg_data
);
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_BUSY = 2'b10
    } t_top_state;

    t_top_state         r_state;
    etsm_pkg::t_in      r_item;
    logic [14:0]        r_tpq;
    logic               r_rebuild;
    logic               r_out_valid;
    etsm_pkg::t_out     r_out;

    logic               w_accept;
    logic               w_commit;
    logic               w_sig_done;
    etsm_pkg::t_sig_res w_sig_res;
    etsm_pkg::t_sum     w_sum;
    etsm_pkg::t_reload  w_reload;

    assign o_ready     = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_valid && o_ready;
    assign w_commit    = (r_state == ST_BUSY) && w_sig_done && (!r_out_valid || i_ready);

    assign w_reload.en  = i_cfg_valid && (i_cfg_index == etsm_pkg::CFG_TPQ);
    assign w_reload.tpq = i_cfg_data;

    etsm_sig #(
        .MAX_SIG_ENTRIES (MAX_SIG_ENTRIES)
    ) u_sig (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_accept),
        .i_item    (r_item),
        .i_tpq     (r_tpq),
        .i_rebuild (r_rebuild),
        .i_reload  (w_reload),
        .i_commit  (w_commit),
        .o_done    (w_sig_done),
        .o_res     (w_sig_res)
    );

    etsm_stats #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_stats (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (r_item),
        .i_commit (w_commit),
        .o_next   (w_sum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tpq       <= etsm_pkg::TPQ_RESET;
            r_rebuild   <= etsm_pkg::REBUILD_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    etsm_pkg::CFG_TPQ:     r_tpq     <= i_cfg_data;
                    etsm_pkg::CFG_REBUILD: r_rebuild <= i_cfg_data[0];
                    default: ;
                endcase
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_item  <= i_data;
                        r_state <= ST_BUSY;
                    end
                end
                ST_BUSY: if (w_commit) r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase

            // hold the result until the downstream transfer
            if (w_commit) begin
                r_out_valid           <= 1'b1;
                r_out.sig_write       <= w_sig_res.write;
                r_out.sig_entry_index <= w_sig_res.index;
                r_out.sig_entry_time  <= w_sig_res.time_tick;
                r_out.sig_beat_len    <= w_sig_res.beat;
                r_out.sig_bar_len     <= w_sig_res.bar;
                r_out.sel_count       <= w_sum.sel_count;
                r_out.min_sel_time    <= w_sum.min_sel;
                r_out.max_sel_time    <= w_sum.max_sel;
                r_out.latest_stop     <= w_sum.stop_max;
                r_out.logical_len     <= w_sum.length;
                r_out.used_mask       <= w_sum.used;
                r_out.selected_mask   <= w_sum.selected;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ----- bench/tb_event_track_summary_and_sig_map.sv -----
// Testbench for event_track_summary_and_sig_map: directed table, then random track passes.
// Checks results against typed rows or the predictor; needs rtl/core/etsm_pkg.sv and top.
`timescale 1ns / 100ps

module tb_event_track_summary_and_sig_map;

    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_TEMPO = 2'd3;
    localparam logic [7:0] MAP_LAST   = 8'd255;
    localparam int SETTLE_CYCLES = 48;
    localparam int MAP_FILL      = 270;
    localparam int NUM_PHASES    = 7;

    localparam etsm_pkg::t_out CLEARED = '{
        sig_write:       1'b0,
        sig_entry_index: 8'd0,
        sig_entry_time:  31'd0,
        sig_beat_len:    17'd0,
        sig_bar_len:     25'd0,
        sel_count:       24'd0,
        min_sel_time:    32'sh7FFFFFFF,
        max_sel_time:    32'sh80000000,
        latest_stop:     32'sd0,
        logical_len:     32'sd0,
        used_mask:       64'd0,
        selected_mask:   64'd0
    };

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    logic           i_valid;
    logic           o_ready;
    etsm_pkg::t_in  i_data;
    logic           o_valid;
    logic           i_ready;
    etsm_pkg::t_out o_data;
    logic           i_cfg_valid;
    logic           o_cfg_ready;
    logic           i_cfg_index;
    logic [14:0]    i_cfg_data;

    event_track_summary_and_sig_map u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Predictor state: registers and the running track summary
    logic [14:0] tpq_reg;
    bit          rebuild_reg;
    logic [23:0] m_sel_cnt;
    int          m_min_sel;
    int          m_max_sel;
    int          m_stop_max;
    int          m_length;
    logic [63:0] m_used;
    logic [63:0] m_selected;
    logic [30:0] m_sig_time;
    logic [16:0] m_beat;
    logic [25:0] m_bar;
    logic [7:0]  m_sig_idx;

    etsm_pkg::t_out expected_summaries[$];
    int             mismatch_count = 0;
    bit             calm = 1'b0;
    int             stall_left = 0;
    longint         track_now;

    etsm_pkg::t_in  dir_ev[$];
    etsm_pkg::t_out dir_res[$];
    bit             dir_typed[$];

    int unsigned phase_tpq[NUM_PHASES]     = '{480, 1, 32767, 0, 480, 0, 96};
    bit          phase_rebuild[NUM_PHASES] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
    int          phase_items[NUM_PHASES]   = '{30, 30, 30, 15, 30, 30, 30};

    function automatic void clear_track();
        m_sel_cnt  = '0;
        m_min_sel  = 32'sh7FFFFFFF;
        m_max_sel  = 32'sh80000000;
        m_stop_max = 0;
        m_length   = 0;
        m_used     = '0;
        m_selected = '0;
        m_sig_time = '0;
        m_beat     = {2'b00, tpq_reg};
        m_bar      = {9'd0, tpq_reg, 2'b00};
        m_sig_idx  = '0;
    endfunction

    function automatic etsm_pkg::t_out summarize_event(etsm_pkg::t_in ev);
        int             first;
        int             last;
        logic [63:0]    ch_bit;
        longint         t;
        longint         d;
        longint         r;
        longint         s;
        logic [31:0]    beat;
        logic [31:0]    bar;
        etsm_pkg::t_out res;
        first  = ev.start_time;
        last   = ev.has_duration ? ev.stop_time : ev.start_time;
        ch_bit = ev.has_channel ? (64'd1 << ev.channel_num) : 64'd0;
        res    = '0;
        m_used |= ch_bit;
        if (ev.event_kind == etsm_pkg::KIND_END) begin
            if (m_length <= 0) m_length = last;
        end else if (ev.event_kind == etsm_pkg::KIND_SIG && rebuild_reg) begin
            t    = (first < 0) ? 64'sd0 : longint'(first);
            beat = {15'd0, tpq_reg, 2'b00} >> ev.sig_denominator_log;
            bar  = beat * {24'd0, ev.sig_numerator};
            // invalid signature falls back to 3/4 bar and quarter beat
            if (bar == 0) bar = {17'd0, tpq_reg} * 32'd3;
            if (beat == 0) beat = {17'd0, tpq_reg};
            if (beat != {15'd0, m_beat} || bar != {6'd0, m_bar}) begin
                d = t - longint'({1'b0, m_sig_time});
                r = (m_bar != 0) ? d % longint'({6'd0, m_bar}) : 64'sd0;
                s = t - r;
                // open a new entry only when the aligned start moved past the current one
                if (s > longint'({1'b0, m_sig_time})) begin
                    if (m_sig_idx < MAP_LAST) m_sig_idx++;
                    m_sig_time = s[30:0];
                end
                m_beat = beat[16:0];
                m_bar  = bar[25:0];
                res.sig_write       = 1'b1;
                res.sig_entry_index = m_sig_idx;
                res.sig_entry_time  = m_sig_time;
                res.sig_beat_len    = beat[16:0];
                res.sig_bar_len     = bar[24:0];
            end
        end
        if (ev.is_selected) begin
            m_selected |= ch_bit;
            if (first < m_min_sel) m_min_sel = first;
            if (last > m_max_sel) m_max_sel = last;
            if (m_sel_cnt != etsm_pkg::SEL_COUNT_MAX) m_sel_cnt++;
        end
        if (last > m_stop_max) m_stop_max = last;
        res.sel_count     = m_sel_cnt;
        res.min_sel_time  = m_min_sel;
        res.max_sel_time  = m_max_sel;
        res.latest_stop   = m_stop_max;
        res.logical_len   = m_length;
        res.used_mask     = m_used;
        res.selected_mask = m_selected;
        if (ev.last_in_track) clear_track();
        return res;
    endfunction

    function automatic int pick_gap();
        int roll;
        if (calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 10);
        return $urandom_range(11, 30);
    endfunction

    function automatic bit field_ok(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic etsm_pkg::t_in mk_event(int start, int stop, bit dur, bit ch_on, int ch,
                                               logic [1:0] kind, bit sel, int num, int den,
                                               bit last);
        etsm_pkg::t_in ev;
        ev.start_time          = start;
        ev.stop_time           = stop;
        ev.has_duration        = dur;
        ev.has_channel         = ch_on;
        ev.channel_num         = ch[5:0];
        ev.event_kind          = kind;
        ev.is_selected         = sel;
        ev.sig_numerator       = num[7:0];
        ev.sig_denominator_log = den[3:0];
        ev.last_in_track       = last;
        return ev;
    endfunction

    function automatic etsm_pkg::t_in random_raw();
        logic [95:0]   raw;
        etsm_pkg::t_in ev;
        raw = {$urandom(), $urandom(), $urandom()};
        ev  = raw[$bits(etsm_pkg::t_in)-1:0];
        ev.last_in_track = 1'b0;
        return ev;
    endfunction

    // Mostly time-ordered event with random content; signature events often cross bar lines
    function automatic etsm_pkg::t_in track_event();
        etsm_pkg::t_in ev;
        int            roll;
        longint        start;
        longint        stop;
        ev   = random_raw();
        roll = $urandom_range(0, 99);
        if (roll < 45)      ev.event_kind = KIND_OTHER;
        else if (roll < 55) ev.event_kind = etsm_pkg::KIND_END;
        else if (roll < 85) ev.event_kind = etsm_pkg::KIND_SIG;
        else                ev.event_kind = KIND_TEMPO;
        if (ev.event_kind == etsm_pkg::KIND_SIG && $urandom_range(0, 2) != 0)
            track_now += $urandom_range(0, 2 * m_bar + 1);
        else
            track_now += $urandom_range(0, 500);
        if (track_now > 64'sh7FFFFFFF) track_now = 64'sh7FFFFFFF;
        start = track_now;
        if ($urandom_range(0, 19) == 0) start = -longint'($urandom_range(1, 100000));
        stop = start + $urandom_range(0, 4000);
        if ($urandom_range(0, 19) == 0) stop = start - $urandom_range(1, 1000);
        if (stop > 64'sh7FFFFFFF) stop = 64'sh7FFFFFFF;
        ev.start_time   = start[31:0];
        ev.has_duration = $urandom_range(0, 1);
        if (ev.has_duration) ev.stop_time = stop[31:0];
        ev.has_channel  = ($urandom_range(0, 3) != 0);
        ev.is_selected  = ($urandom_range(0, 2) == 0);
        roll = $urandom_range(0, 9);
        if (roll == 0)      ev.sig_numerator = 8'd0;
        else if (roll == 1) ev.sig_numerator = 8'($urandom_range(0, 255));
        else                ev.sig_numerator = 8'($urandom_range(1, 12));
        if ($urandom_range(0, 9) == 0) ev.sig_denominator_log = 4'($urandom_range(0, 15));
        else                           ev.sig_denominator_log = 4'($urandom_range(0, 4));
        return ev;
    endfunction

    task automatic add_row(etsm_pkg::t_in ev, bit typed, etsm_pkg::t_out res);
        dir_ev.push_back(ev);
        dir_typed.push_back(typed);
        dir_res.push_back(res);
    endtask

    task automatic send_event(etsm_pkg::t_in ev, bit typed, etsm_pkg::t_out want);
        int             gap;
        etsm_pkg::t_out pred;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= ev;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pred = summarize_event(ev);
        expected_summaries.push_back(typed ? want : pred);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [14:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == etsm_pkg::CFG_TPQ) begin
            tpq_reg = val;
            m_beat  = {2'b00, val};
            m_bar   = {9'd0, val, 2'b00};
        end else begin
            rebuild_reg = val[0];
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (expected_summaries.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Long metered pass: alternate 3/x and 4/x past every bar until the map saturates
    task automatic fill_sig_map();
        etsm_pkg::t_in ev;
        track_now = 0;
        for (int k = 0; k < MAP_FILL; k++) begin
            ev = random_raw();
            ev.event_kind          = etsm_pkg::KIND_SIG;
            ev.start_time          = track_now[31:0];
            ev.sig_numerator       = k[0] ? 8'd3 : 8'd4;
            ev.sig_denominator_log = 4'($urandom_range(0, 3));
            ev.last_in_track       = (k == MAP_FILL - 1);
            send_event(ev, 1'b0, CLEARED);
            track_now += m_bar + $urandom_range(0, m_bar);
        end
    endtask

    task automatic run_passes(int count);
        int            done;
        int            len;
        etsm_pkg::t_in ev;
        done = 0;
        while (done < count) begin
            len       = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 30);
            calm      = ($urandom_range(0, 4) == 0);
            track_now = $urandom_range(0, 2000);
            for (int k = 0; k < len; k++) begin
                // a tenth of the items are raw noise
                ev = ($urandom_range(0, 9) == 0) ? random_raw() : track_event();
                ev.last_in_track = (k == len - 1);
                send_event(ev, 1'b0, CLEARED);
            end
            done += len;
        end
        calm = 1'b0;
    endtask

    task automatic load_table();
        etsm_pkg::t_out r;
        r = CLEARED;
        r.latest_stop = 100;
        add_row(mk_event(100, 0, 0, 0, 0, KIND_OTHER, 0, 0, 0, 0), 1'b1, r);
        add_row(mk_event(50, 300, 1, 1, 0, KIND_OTHER, 0, 0, 0, 0), 1'b0, CLEARED);
        add_row(mk_event(0, 0, 0, 0, 0, etsm_pkg::KIND_END, 0, 0, 0, 0), 1'b0, CLEARED);
        add_row(mk_event(-5, 0, 0, 0, 0, etsm_pkg::KIND_END, 0, 0, 0, 0), 1'b0, CLEARED);
        add_row(mk_event(200, 1000, 1, 0, 0, etsm_pkg::KIND_END, 0, 0, 0, 0), 1'b0, CLEARED);
        add_row(mk_event(400, 0, 0, 0, 0, etsm_pkg::KIND_END, 0, 0, 0, 0), 1'b0, CLEARED);
        // same signature as the implicit 4/4 entry
        add_row(mk_event(500, 0, 0, 0, 0, etsm_pkg::KIND_SIG, 0, 4, 2, 0), 1'b0, CLEARED);
        r = CLEARED;
        r.sig_write       = 1'b1;
        r.sig_entry_index = 8'd1;
        r.sig_entry_time  = 31'd1920;
        r.sig_beat_len    = 17'd480;
        r.sig_bar_len     = 25'd1440;
        r.latest_stop     = 2000;
        r.logical_len     = 1000;
        r.used_mask       = 64'd1;
        add_row(mk_event(2000, 0, 0, 0, 0, etsm_pkg::KIND_SIG, 0, 3, 2, 0), 1'b1, r);
        add_row(mk_event(2500, 0, 0, 0, 0, etsm_pkg::KIND_SIG, 0, 0, 0, 0), 1'b0, CLEARED);
        add_row(mk_event(1000, 0, 0, 0, 0, etsm_pkg::KIND_SIG, 0, 7, 15, 0), 1'b0, CLEARED);
        add_row(mk_event(-300, 0, 0, 0, 0, etsm_pkg::KIND_SIG, 0, 2, 1, 0), 1'b0, CLEARED);
        add_row(mk_event(32'h7FFFFFFF, 0, 0, 0, 0, etsm_pkg::KIND_SIG, 0, 255, 0, 0),
                1'b0, CLEARED);
        add_row(mk_event(3000, 3100, 1, 1, 5, KIND_TEMPO, 1, 0, 0, 0), 1'b0, CLEARED);
        add_row(mk_event(32'h80000000, 32'h7FFFFFFF, 1, 1, 63, KIND_OTHER, 1, 255, 15, 1),
                1'b0, CLEARED);
        add_row(mk_event(0, 0, 0, 0, 0, KIND_OTHER, 0, 0, 0, 0), 1'b1, CLEARED);
        r = CLEARED;
        r.sig_write       = 1'b1;
        r.sig_beat_len    = 17'd480;
        r.sig_bar_len     = 25'd1440;
        r.latest_stop     = 100;
        add_row(mk_event(100, 0, 0, 0, 0, etsm_pkg::KIND_SIG, 0, 3, 2, 0), 1'b1, r);
        add_row(mk_event(7, 0, 0, 0, 0, KIND_OTHER, 0, 0, 0, 1), 1'b0, CLEARED);
    endtask

    // Sink side: random stalls on the result channel
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left--;
        end else begin
            i_ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        etsm_pkg::t_out want;
        bit             ok;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_summaries.size() == 0) begin
                $display("%0t: result with none expected, actual %0h", $time, o_data);
                mismatch_count++;
            end else begin
                want = expected_summaries.pop_front();
                ok = 1'b1;
                ok &= field_ok("sig_write", want.sig_write, o_data.sig_write);
                ok &= field_ok("sig_entry_index", want.sig_entry_index, o_data.sig_entry_index);
                ok &= field_ok("sig_entry_time", want.sig_entry_time, o_data.sig_entry_time);
                ok &= field_ok("sig_beat_len", want.sig_beat_len, o_data.sig_beat_len);
                ok &= field_ok("sig_bar_len", want.sig_bar_len, o_data.sig_bar_len);
                ok &= field_ok("sel_count", want.sel_count, o_data.sel_count);
                ok &= field_ok("min_sel_time", want.min_sel_time, o_data.min_sel_time);
                ok &= field_ok("max_sel_time", want.max_sel_time, o_data.max_sel_time);
                ok &= field_ok("latest_stop", want.latest_stop, o_data.latest_stop);
                ok &= field_ok("logical_len", want.logical_len, o_data.logical_len);
                ok &= field_ok("used_mask", want.used_mask, o_data.used_mask);
                ok &= field_ok("selected_mask", want.selected_mask, o_data.selected_mask);
                if (!ok) mismatch_count++;
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data      = '0;
        i_ready     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = etsm_pkg::CFG_TPQ;
        i_cfg_data  = '0;
        tpq_reg     = etsm_pkg::TPQ_RESET;
        rebuild_reg = etsm_pkg::REBUILD_RESET;
        clear_track();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        load_table();
        foreach (dir_ev[i]) send_event(dir_ev[i], dir_typed[i], dir_res[i]);
        settle();

        phase_tpq[5] = $urandom_range(2, 32766);
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_reg(etsm_pkg::CFG_TPQ, phase_tpq[p][14:0]);
            write_reg(etsm_pkg::CFG_REBUILD, {14'd0, phase_rebuild[p]});
            if (p == 0) fill_sig_map();
            run_passes(phase_items[p]);
            settle();
        end

        if (mismatch_count == 0 && expected_summaries.size() == 0)
            $display("tb_event_track_summary_and_sig_map: PASS");
        else
            $display("tb_event_track_summary_and_sig_map: FAIL");
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #10_000_000;
        $display("tb_event_track_summary_and_sig_map: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/etsm_pkg.sv
rtl/core/etsm_div.sv
rtl/core/etsm_stats.sv
rtl/core/etsm_sig.sv
rtl/core/event_track_summary_and_sig_map.sv
bench/tb_event_track_summary_and_sig_map.sv
